// File: rtl/core/itoa_pkg.sv
// itoa_pkg: shared types, character codes and microcode program for the
// signed integer to decimal ascii converter. no dependencies.
`default_nettype none

package itoa_pkg;

  // ascii character codes
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  // program counter
  localparam int PC_BITS = 3;
  typedef logic [PC_BITS-1:0] pc_t;

  localparam pc_t STEP_IDLE   = 3'd0;
  localparam pc_t STEP_DABBLE = 3'd1;
  localparam pc_t STEP_SKIPZ  = 3'd2;
  localparam pc_t STEP_SIGN   = 3'd3;
  localparam pc_t STEP_DIGIT  = 3'd4;
  localparam pc_t STEP_DONE   = 3'd5;

  // datapath operations
  typedef logic [2:0] op_t;
  localparam op_t OP_IDLE   = 3'd0;  // wait for start, load operand
  localparam op_t OP_DABBLE = 3'd1;  // add-3 and shift one bit into bcd
  localparam op_t OP_SKIPZ  = 3'd2;  // drop one leading zero digit
  localparam op_t OP_SIGN   = 3'd3;  // emit minus sign if negative
  localparam op_t OP_DIGIT  = 3'd4;  // emit top digit and shift it out
  localparam op_t OP_NOP    = 3'd5;

  // jump conditions
  typedef logic [2:0] cond_t;
  localparam cond_t COND_ALWAYS      = 3'd0;
  localparam cond_t COND_NO_START    = 3'd1;
  localparam cond_t COND_BITS_LEFT   = 3'd2;
  localparam cond_t COND_LEAD_ZERO   = 3'd3;
  localparam cond_t COND_DIGITS_LEFT = 3'd4;

  // one control word: jump to target when cond holds, else fall through
  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(input pc_t pc);
    ctrl_word_t cw;
    unique case (pc)
      STEP_IDLE:   cw = '{op: OP_IDLE,   cond: COND_NO_START,    target: STEP_IDLE};
      STEP_DABBLE: cw = '{op: OP_DABBLE, cond: COND_BITS_LEFT,   target: STEP_DABBLE};
      STEP_SKIPZ:  cw = '{op: OP_SKIPZ,  cond: COND_LEAD_ZERO,   target: STEP_SKIPZ};
      STEP_SIGN:   cw = '{op: OP_SIGN,   cond: COND_ALWAYS,      target: STEP_DIGIT};
      STEP_DIGIT:  cw = '{op: OP_DIGIT,  cond: COND_DIGITS_LEFT, target: STEP_DIGIT};
      STEP_DONE:   cw = '{op: OP_NOP,    cond: COND_ALWAYS,      target: STEP_IDLE};
      default:     cw = '{op: OP_NOP,    cond: COND_ALWAYS,      target: STEP_IDLE};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/signed_int_to_decimal_ascii.sv
// signed_int_to_decimal_ascii: microcoded converter from a signed binary
// word to decimal ascii text. depends on itoa_pkg (types, codes, program rom).
`default_nettype none

// A word is taken on a rising edge with start high and busy low. Its text
// comes out one character per strobe on out_valid: a '-' first when the
// value is negative, then the decimal digits most significant first with no
// leading zeros (zero gives a single "0"), out_last marking the final digit.
// The most negative value converts exactly. The receiver cannot stall, so
// every strobe lasts one cycle and must be caught. A word first runs the
// shift-and-add-3 loop, one operand bit per cycle, then drops its leading
// zero digits until the first kept digit shows, takes one sign step,
// emits its D digits and ends with one closing step, where Z + D = NDIG
// (10 digits at 32 bits) and Z is the number of leading zero digits dropped.
// Control runs from a six-step program rom with a step counter and
// conditional jumps.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire signed [VALUE_BITS-1:0] in_value,
  output logic                        out_valid,
  output logic [7:0]                  out_char_code,
  output logic                        out_last
);

  // digit count for a magnitude up to 2^(VALUE_BITS-1)
  localparam int NDIG     = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BCD_BITS = NDIG * 4;
  localparam int BCNT_W   = $clog2(VALUE_BITS + 1);
  localparam int DCNT_W   = $clog2(NDIG + 1);

  // sequencer state
  itoa_pkg::pc_t pc_r, pc_nxt;
  itoa_pkg::ctrl_word_t cw;
  logic cond_true;

  // datapath registers
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;     // magnitude, shifted out msb first
  logic [BCD_BITS-1:0]   bcd_r, bcd_nxt;     // packed bcd digits
  logic [BCD_BITS-1:0]   bcd_adj;            // digits after add-3 correction
  logic                  neg_r, neg_nxt;
  logic [BCNT_W-1:0]     bcnt_r, bcnt_nxt;   // operand bits still to shift
  logic [DCNT_W-1:0]     dcnt_r, dcnt_nxt;   // digit positions still held
  logic [3:0]            top_digit;
  logic                  lead_zero;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;

  assign cw        = itoa_pkg::ucode_rom(pc_r);
  assign busy      = (pc_r != itoa_pkg::STEP_IDLE);
  assign top_digit = bcd_r[BCD_BITS-1 -: 4];
  // a leading zero can go as long as one digit stays behind
  assign lead_zero = (top_digit == 4'd0) && (dcnt_r != DCNT_W'(1));

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? (bcd_r[i*4 +: 4] + 4'd3)
                                                     : bcd_r[i*4 +: 4];
    end
  end

  // jump condition select
  always_comb begin
    unique case (cw.cond)
      itoa_pkg::COND_ALWAYS:      cond_true = 1'b1;
      itoa_pkg::COND_NO_START:    cond_true = !start;
      itoa_pkg::COND_BITS_LEFT:   cond_true = (bcnt_r != BCNT_W'(1));
      itoa_pkg::COND_LEAD_ZERO:   cond_true = lead_zero;
      itoa_pkg::COND_DIGITS_LEFT: cond_true = (dcnt_r != DCNT_W'(1));
      default:                    cond_true = 1'b0;
    endcase
  end

  assign pc_nxt = cond_true ? cw.target : itoa_pkg::pc_t'(pc_r + 1'b1);

  // datapath driven by the current control word
  always_comb begin
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    bcnt_nxt      = bcnt_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = 1'b0;
    unique case (cw.op)
      itoa_pkg::OP_IDLE: begin
        if (start) begin
          // magnitude formed unsigned so the most negative value is exact
          neg_nxt  = in_value[VALUE_BITS-1];
          mag_nxt  = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;
          bcd_nxt  = '0;
          bcnt_nxt = BCNT_W'(VALUE_BITS);
          dcnt_nxt = DCNT_W'(NDIG);
        end
      end
      itoa_pkg::OP_DABBLE: begin
        {bcd_nxt, mag_nxt} = {bcd_adj[BCD_BITS-2:0], mag_r, 1'b0};
        bcnt_nxt           = bcnt_r - 1'b1;
      end
      itoa_pkg::OP_SKIPZ: begin
        if (lead_zero) begin
          bcd_nxt  = {bcd_r[BCD_BITS-5:0], 4'd0};
          dcnt_nxt = dcnt_r - 1'b1;
        end
      end
      itoa_pkg::OP_SIGN: begin
        out_valid_nxt = neg_r;
        out_char_nxt  = itoa_pkg::ASCII_MINUS;
      end
      itoa_pkg::OP_DIGIT: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = itoa_pkg::ASCII_ZERO + {4'd0, top_digit};
        out_last_nxt  = (dcnt_r == DCNT_W'(1));
        bcd_nxt       = {bcd_r[BCD_BITS-5:0], 4'd0};
        dcnt_nxt      = dcnt_r - 1'b1;
      end
      itoa_pkg::OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= itoa_pkg::STEP_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    neg_r      <= neg_nxt;
    bcnt_r     <= bcnt_nxt;
    dcnt_r     <= dcnt_nxt;
    out_char_r <= out_char_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

  // a character only appears while a word is in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("character strobe outside a conversion");

  // last mark only on a strobed character
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("last mark without strobe");

  // the sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_char_code == itoa_pkg::ASCII_MINUS) |-> !out_last)
    else $error("minus sign marked last");

  // an accepted word keeps the block busy next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not start conversion");

  // nothing follows the last character back to back
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("character strobed after last mark");

endmodule

`default_nettype wire

// File: tb/itoa_text_checker.sv
// itoa_text_checker: watches the word and character channels of the
// signed_int_to_decimal_ascii block, predicts each word's text and compares.
// depends on itoa_pkg for the ascii codes.
module itoa_text_checker #(
  parameter int VALUE_BITS = 32
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  wire                  busy,
  input  wire [VALUE_BITS-1:0] in_value,
  input  wire                  out_valid,
  input  wire [7:0]            out_char_code,
  input  wire                  out_last,
  output logic [31:0]          fail_count,
  output logic [31:0]          chars_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } text_char_t;

  text_char_t text_expected_q[$];
  text_char_t want;
  int         fails = 0;
  int         pending = 0;

  assign fail_count    = fails;
  assign chars_pending = pending;

  // sign first, then digits most significant first, last on the final digit
  task automatic push_text(input logic [VALUE_BITS-1:0] word);
    logic [VALUE_BITS-1:0] mag_w;
    logic [63:0]           magnitude;
    logic [7:0]            digits[$];
    logic                  negative;
    negative  = word[VALUE_BITS-1];
    mag_w     = negative ? (~word + 1'b1) : word;
    magnitude = '0;
    magnitude[VALUE_BITS-1:0] = mag_w;
    do begin
      digits.push_front(8'(magnitude % 64'd10));
      magnitude = magnitude / 64'd10;
    end while (magnitude != 0);
    if (negative) begin
      text_expected_q.push_back(text_char_t'{itoa_pkg::ASCII_MINUS, 1'b0});
    end
    foreach (digits[i]) begin
      text_expected_q.push_back(text_char_t'{itoa_pkg::ASCII_ZERO + digits[i],
                                             i == digits.size() - 1});
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        push_text(in_value);
      end
      if (out_valid) begin
        if (text_expected_q.size() == 0) begin
          if (fails < 10) begin
            $display("%0t: character 0x%02h last %0b with no word pending",
                     $realtime, out_char_code, out_last);
          end
          fails = fails + 1;
        end else begin
          want = text_expected_q.pop_front();
          if (out_char_code !== want.char_code || out_last !== want.last) begin
            if (fails < 10) begin
              $display("%0t: char expected 0x%02h got 0x%02h, last expected %0b got %0b",
                       $realtime, want.char_code, out_char_code, want.last, out_last);
            end
            fails = fails + 1;
          end
        end
      end
      pending <= text_expected_q.size();
    end
  end

endmodule

// File: tb/testbench.sv
// testbench: drives signed words into signed_int_to_decimal_ascii and
// gives the verdict; checking lives in itoa_text_checker. depends on itoa_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_BITS = 32;
  localparam int WORDS_PER_PHASE = 84;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic                  busy;
  logic                  out_valid;
  logic [7:0]            out_char_code;
  logic                  out_last;
  logic [31:0]           fail_count;
  logic [31:0]           chars_pending;

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_char_code(out_char_code),
    .out_last     (out_last)
  );

  itoa_text_checker #(
    .VALUE_BITS(VALUE_BITS)
  ) i_text_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_char_code(out_char_code),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .chars_pending(chars_pending)
  );

  // present one word and hold it until the block takes it
  task automatic send_word(input logic [VALUE_BITS-1:0] word);
    start    <= 1'b1;
    in_value <= word;
    do @(posedge clk); while (busy);
  endtask

  // drop start and sit until every character of every taken word is out
  task automatic wait_text_drained();
    start <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  // mostly words of a chosen digit count, some near powers of ten, some raw bits
  function automatic logic [VALUE_BITS-1:0] rand_word();
    logic [VALUE_BITS-1:0] mag;
    int unsigned           ndig;
    int unsigned           lo;
    int unsigned           hi;
    int unsigned           pow;
    pow = 1;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        mag = $urandom();
      end
      3: begin
        // just below, at or just above a power of ten
        repeat ($urandom_range(0, 9)) pow = pow * 10;
        mag = pow + $urandom_range(0, 2) - 1;
      end
      default: begin
        ndig = $urandom_range(1, 10);
        repeat (ndig - 1) pow = pow * 10;
        lo  = (ndig == 1) ? 0 : pow;
        hi  = (ndig == 10) ? 32'h7fff_ffff : pow * 10 - 1;
        mag = $urandom_range(hi, lo);
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      mag = ~mag + 1'b1;
    end
    return mag;
  endfunction

  // directed words: zero, one-digit and sign edges, digit count steps,
  // the most positive and the most negative value, alternating bit patterns
  logic [VALUE_BITS-1:0] directed_words[] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    32'd999_999_999, 32'd1_000_000_000, -32'sd999_999_999, -32'sd1_000_000_000,
    32'd123_456_789, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001,
    32'h5555_5555, 32'haaaa_aaaa, 32'd2_000_000_000, 32'd1_000_000_001
  };

  initial begin
    int idle_pct;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_words[i]) begin
      send_word(directed_words[i]);
    end
    // sender holds off until the whole directed text is out
    wait_text_drained();

    // sender idles 13 percent, then 81 percent, then never
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 13 : (phase == 1) ? 81 : 0;
      repeat (WORDS_PER_PHASE) begin
        if ($urandom_range(0, 99) < idle_pct) begin
          // gap length spread over the whole conversion so it hits every step
          start <= 1'b0;
          repeat ($urandom_range(1, 60)) @(posedge clk);
        end
        send_word(rand_word());
      end
      wait_text_drained();
    end

    // room for any stray character after the last expected one
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("signed_int_to_decimal_ascii regression: pass");
    end else begin
      $display("signed_int_to_decimal_ascii regression: fail");
    end
    $finish;
  end

  // hang guard, several times the slowest correct run
  initial begin
    #2_000_000;
    $display("signed_int_to_decimal_ascii regression: fail");
    $finish;
  end

endmodule
